// ===== rtl/core/jsu_pkg.sv =====
package jsu_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] kind_t;
  typedef logic [3:0] ecode_t;

  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_END  = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  localparam ecode_t ERR_NONE      = 4'd0;
  localparam ecode_t ERR_EXP_QUOTE = 4'd1;
  localparam ecode_t ERR_CTRL_CHAR = 4'd2;
  localparam ecode_t ERR_UNT_ESC   = 4'd3;
  localparam ecode_t ERR_BAD_ESC   = 4'd4;
  localparam ecode_t ERR_UNT_UNI   = 4'd5;
  localparam ecode_t ERR_BAD_HEX   = 4'd6;
  localparam ecode_t ERR_MISS_LO   = 4'd7;
  localparam ecode_t ERR_BAD_LO    = 4'd8;
  localparam ecode_t ERR_UNT_STR   = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one input byte's worth of results: up to four bytes, or one end/error result
  typedef struct packed {
    logic [1:0]      cnt_m1;
    logic [3:0][7:0] bytes;
    kind_t           kind;
    ecode_t          code;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bnd;
  } q_wr_t;

  typedef struct packed {
    logic    vld;
    bundle_t bnd;
  } q_head_t;

  localparam logic [20:0] CP_1B_MAX = 21'h00007F;
  localparam logic [20:0] CP_2B_MAX = 21'h0007FF;
  localparam logic [20:0] CP_3B_MAX = 21'h00FFFF;

  function automatic bundle_t utf8_enc(input logic [20:0] cp);
    bundle_t b;
    b = '0;
    b.kind = KIND_BYTE;
    b.code = ERR_NONE;
    if (cp <= CP_1B_MAX) begin
      b.cnt_m1   = 2'd0;
      b.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= CP_2B_MAX) begin
      b.cnt_m1   = 2'd1;
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= CP_3B_MAX) begin
      b.cnt_m1   = 2'd2;
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      b.cnt_m1   = 2'd3;
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/jsu_ifs.sv =====
interface jsu_in_if;
  logic           valid;
  logic           ready;
  jsu_pkg::byte_t data_byte;
  logic           source_end;

  modport source (output valid, output data_byte, output source_end, input ready);
  modport sink   (input valid, input data_byte, input source_end, output ready);
endinterface

interface jsu_out_if;
  logic            valid;
  logic            ready;
  jsu_pkg::byte_t  out_byte;
  jsu_pkg::kind_t  kind;
  jsu_pkg::ecode_t error_code;
  logic            last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

// ===== rtl/core/jsu_front.sv =====
module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  jsu_in_if.sink         in_chan,
  input  logic           q_full,
  output jsu_pkg::q_wr_t q_wr
);
  import jsu_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_STR     = 3'd1;
  localparam logic [2:0] M_ESC     = 3'd2;
  localparam logic [2:0] M_HEX_HI  = 3'd3;
  localparam logic [2:0] M_NEED_BS = 3'd4;
  localparam logic [2:0] M_NEED_U  = 3'd5;
  localparam logic [2:0] M_HEX_LO  = 3'd6;

  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_LOW_B  = 8'h62;
  localparam byte_t CH_LOW_F  = 8'h66;
  localparam byte_t CH_LOW_N  = 8'h6E;
  localparam byte_t CH_LOW_R  = 8'h72;
  localparam byte_t CH_LOW_T  = 8'h74;
  localparam byte_t CH_LOW_U  = 8'h75;

  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUP_BASE   = 21'h010000;

  // {ok, value}
  function automatic logic [4:0] hex_dec(input byte_t c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic bundle_t one_byte(input byte_t b);
    bundle_t r;
    r = '0;
    r.kind     = KIND_BYTE;
    r.code     = ERR_NONE;
    r.bytes[0] = b;
    return r;
  endfunction

  logic [2:0]  mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;   // at most three digits are held before the group closes
  logic [9:0]  hs_r, hs_nxt;

  logic        accept;
  byte_t       c;
  logic        src_end;
  logic [4:0]  hx;
  logic [15:0] grp;
  logic [20:0] cp_pair;
  logic        push;
  bundle_t     bnd;
  ecode_t      err;

  assign c       = in_chan.data_byte;
  assign src_end = in_chan.source_end;
  assign in_chan.ready = !q_full;
  assign accept  = in_chan.valid && in_chan.ready;
  assign hx      = hex_dec(c);
  assign grp     = {acc_r, hx[3:0]};
  assign cp_pair = SUP_BASE + {1'b0, hs_r, grp[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    push     = 1'b0;
    bnd      = '0;
    err      = ERR_NONE;
    case (mode_r)
      M_STR: begin
        if (src_end) begin
          err = ERR_UNT_STR;
        end else if (c == CH_QUOTE) begin
          push     = 1'b1;
          bnd.kind = KIND_END;
          mode_nxt = M_IDLE;
        end else if (c < CH_SPACE) begin
          err = ERR_CTRL_CHAR;
        end else if (c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          push = 1'b1;
          bnd  = one_byte(c);
        end
      end
      M_ESC: begin
        if (src_end) begin
          err = ERR_UNT_ESC;
        end else begin
          mode_nxt = M_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              push = 1'b1;
              bnd  = one_byte(c);
            end
            CH_LOW_B: begin push = 1'b1; bnd = one_byte(8'h08); end
            CH_LOW_F: begin push = 1'b1; bnd = one_byte(8'h0C); end
            CH_LOW_N: begin push = 1'b1; bnd = one_byte(8'h0A); end
            CH_LOW_R: begin push = 1'b1; bnd = one_byte(8'h0D); end
            CH_LOW_T: begin push = 1'b1; bnd = one_byte(8'h09); end
            CH_LOW_U: begin
              mode_nxt = M_HEX_HI;
              cnt_nxt  = 2'd0;
              acc_nxt  = '0;
            end
            default: err = ERR_BAD_ESC;
          endcase
        end
      end
      M_HEX_HI: begin
        if (src_end) begin
          err = ERR_UNT_UNI;
        end else if (!hx[4]) begin
          err = ERR_BAD_HEX;
        end else if (cnt_r == 2'd3) begin
          cnt_nxt = 2'd0;
          acc_nxt = '0;
          if (grp >= SUR_HI_MIN && grp <= SUR_HI_MAX) begin
            hs_nxt   = grp[9:0];
            mode_nxt = M_NEED_BS;
          end else begin
            push     = 1'b1;
            bnd      = utf8_enc({5'd0, grp});
            mode_nxt = M_STR;
          end
        end else begin
          acc_nxt = {acc_r[7:0], hx[3:0]};
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      M_NEED_BS: begin
        if (src_end || c != CH_BSLASH) err = ERR_MISS_LO;
        else                           mode_nxt = M_NEED_U;
      end
      M_NEED_U: begin
        if (src_end || c != CH_LOW_U) begin
          err = ERR_MISS_LO;
        end else begin
          mode_nxt = M_HEX_LO;
          cnt_nxt  = 2'd0;
          acc_nxt  = '0;
        end
      end
      M_HEX_LO: begin
        if (src_end) begin
          err = ERR_UNT_UNI;
        end else if (!hx[4]) begin
          err = ERR_BAD_HEX;
        end else if (cnt_r == 2'd3) begin
          if (grp < SUR_LO_MIN || grp > SUR_LO_MAX) begin
            err = ERR_BAD_LO;
          end else begin
            push     = 1'b1;
            bnd      = utf8_enc(cp_pair);
            cnt_nxt  = 2'd0;
            acc_nxt  = '0;
            hs_nxt   = '0;
            mode_nxt = M_STR;
          end
        end else begin
          acc_nxt = {acc_r[7:0], hx[3:0]};
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      default: begin
        // idle, and the unused mode code
        if (!src_end && !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_STR;
            cnt_nxt  = 2'd0;
            acc_nxt  = '0;
            hs_nxt   = '0;
          end else begin
            err = ERR_EXP_QUOTE;
          end
        end
      end
    endcase
    if (err != ERR_NONE) begin
      push     = 1'b1;
      bnd      = '0;
      bnd.kind = KIND_ERR;
      bnd.code = err;
      mode_nxt = M_IDLE;
      cnt_nxt  = 2'd0;
      acc_nxt  = '0;
      hs_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r  <= 2'd0;
      acc_r  <= '0;
      hs_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

  assign q_wr.push = accept && push;
  assign q_wr.bnd  = bnd;

  a_hs_only_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (hs_r != '0) |-> (mode_r == M_NEED_BS || mode_r == M_NEED_U || mode_r == M_HEX_LO))
    else $error("surrogate bits held outside pair decoding");

  a_cnt_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> (mode_r == M_HEX_HI || mode_r == M_HEX_LO))
    else $error("hex digit count set outside a hex group");

endmodule

// ===== rtl/core/jsu_queue.sv =====
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::q_wr_t    q_wr,
  output logic              q_full,
  output jsu_pkg::q_head_t  q_head,
  input  logic              pop
);
  import jsu_pkg::*;

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_full      = (cnt_r == QCNT_W'(QDEPTH));
  assign q_head.vld  = (cnt_r != '0);
  assign q_head.bnd  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(q_wr.push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(q_wr.push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr_r] <= q_wr.bnd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_head.vld))
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/jsu_back.sv =====
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::q_head_t  q_head,
  output logic              pop,
  jsu_out_if.source         out_chan
);
  import jsu_pkg::*;

  logic   vld_r, vld_nxt;
  logic   [1:0] idx_r, idx_nxt;
  byte_t  byte_r;
  kind_t  kind_r;
  ecode_t code_r;
  logic   last_r;
  logic   load;
  logic   is_last;

  assign load    = q_head.vld && (!vld_r || out_chan.ready);
  assign is_last = (idx_r == q_head.bnd.cnt_m1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_chan.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_head.bnd.bytes[idx_r];
      kind_r <= q_head.bnd.kind;
      code_r <= q_head.bnd.code;
      last_r <= is_last;
    end
  end

  assign out_chan.valid      = vld_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.kind       = kind_r;
  assign out_chan.error_code = code_r;
  assign out_chan.last       = last_r;

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    q_head.vld |-> (idx_r <= q_head.bnd.cnt_m1))
    else $error("result index past end of bundle");

endmodule

// ===== rtl/core/json_string_unescape_utf8_core.sv =====
// JSON string unescaper to UTF-8.
// in_chan carries one source byte per transfer (data_byte, source_end); out_chan
// carries one result per transfer: a decoded byte, a string-end mark or an error
// code, with last set on the final result caused by an input byte.
// The front decoder takes one input byte per cycle while the queue is not full and
// turns it into a bundle of zero to four results, pushed into a four-entry queue.
// The back stage drains the head bundle one result per cycle into the output
// register while out_chan.ready does not stall it. Each result is written into
// the queue and then loaded into the output register before out_chan offers it.
// Throughput: one input byte per cycle while each byte yields at most one result and
// out_chan.ready stays high; a \u escape closing into two to four UTF-8 bytes drains
// one byte per output transfer, and the queue absorbs such bursts. Input ready is low
// only while the queue is full. When out_chan.ready is held low the output register
// holds its result, the queue fills, and then in_chan.ready drops; nothing is lost.
// Reset (synchronous, rst_n low) returns the decoder to idle, awaiting an opening
// quote, and empties the queue and the output register.
module json_string_unescape_utf8_core (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);
  import jsu_pkg::*;

  q_wr_t   q_wr;
  q_head_t q_head;
  logic    q_full;
  logic    pop;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  jsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .pop    (pop)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STR     = 3'd1,
    M_ESC     = 3'd2,
    M_HEX_HI  = 3'd3,
    M_NEED_BS = 3'd4,
    M_NEED_U  = 3'd5,
    M_HEX_LO  = 3'd6
  } dec_mode_t;

  typedef struct packed {
    byte_t  b;
    kind_t  k;
    ecode_t c;
    logic   last;
  } dec_res_t;

  typedef struct packed {
    byte_t d;
    logic  eos;
  } src_item_t;

  // known = 1: the row's single result is written out by hand
  typedef struct packed {
    byte_t  d;
    logic   eos;
    logic   known;
    kind_t  k;
    ecode_t c;
    byte_t  b;
  } stim_row_t;

  localparam stim_row_t STIM_TABLE [25] = '{
    '{8'h00,     1'b1, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{8'h0D,     1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"x",       1'b0, 1'b1, KIND_ERR,  ERR_EXP_QUOTE, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{8'hFF,     1'b0, 1'b1, KIND_BYTE, ERR_NONE,      8'hFF},
    '{8'h1F,     1'b0, 1'b1, KIND_ERR,  ERR_CTRL_CHAR, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"q",       1'b0, 1'b1, KIND_ERR,  ERR_BAD_ESC,   8'h00},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"u",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"D",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"B",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"f",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"F",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"u",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"D",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"F",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"F",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{"F",       1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, ERR_NONE,      8'h00},
    '{8'h00,     1'b1, 1'b1, KIND_ERR,  ERR_UNT_ESC,   8'h00},
    '{8'hA5,     1'b1, 1'b0, KIND_BYTE, ERR_NONE,      8'h00}
  };

  logic clk;
  logic rst_n;

  jsu_in_if  in_if();
  jsu_out_if out_if();

  json_string_unescape_utf8_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // decoder shadow state
  dec_mode_t   pmode;
  logic [1:0]  hex_cnt;
  logic [15:0] hex_acc;
  logic [9:0]  hi_bits;

  dec_res_t step_res[$];
  dec_res_t pending_decodes[$];

  int unsigned mismatches;
  int unsigned live_items;
  int unsigned src_items;
  int unsigned n_bytes;
  int unsigned n_ends;
  int unsigned n_errs;
  logic [15:0] codes_seen;
  int unsigned cycle_cnt;
  bit          calm;
  bit          hold_req;

  function automatic void reset_decoder();
    pmode   = M_IDLE;
    hex_cnt = 2'd0;
    hex_acc = 16'h0;
    hi_bits = 10'h0;
  endfunction

  function automatic void emit(input byte_t b, input kind_t k, input ecode_t c);
    step_res.insert(step_res.size(), '{b, k, c, 1'b0});
  endfunction

  function automatic void abort_string(input ecode_t c);
    emit(8'h00, KIND_ERR, c);
    reset_decoder();
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(byte_t'(cp), KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      emit(8'hC0 | byte_t'(cp >> 6), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'(cp & 21'h3F), KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      emit(8'hE0 | byte_t'(cp >> 12), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'((cp >> 6) & 21'h3F), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'(cp & 21'h3F), KIND_BYTE, ERR_NONE);
    end else begin
      emit(8'hF0 | byte_t'((cp >> 18) & 21'h07), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'((cp >> 12) & 21'h3F), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'((cp >> 6) & 21'h3F), KIND_BYTE, ERR_NONE);
      emit(8'h80 | byte_t'(cp & 21'h3F), KIND_BYTE, ERR_NONE);
    end
  endfunction

  function automatic bit hex_nibble(input byte_t c, output logic [3:0] n);
    n = 4'h0;
    if (c >= "0" && c <= "9") n = 4'(c - "0");
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // Advances the shadow decoder by one source byte and, when keep is set, queues its results.
  // Returns 1 when the byte was only skipped by the idle decoder.
  function automatic bit decode_source_byte(input byte_t c, input logic eos, input bit keep);
    logic [3:0]  nib;
    logic [15:0] v;
    bit          skipped;
    skipped = 1'b0;
    step_res.delete();
    case (pmode)
      M_STR: begin
        if (eos) abort_string(ERR_UNT_STR);
        else if (c == CH_QUOTE) begin
          emit(8'h00, KIND_END, ERR_NONE);
          reset_decoder();
        end else if (c < 8'h20) abort_string(ERR_CTRL_CHAR);
        else if (c == CH_BSLASH) pmode = M_ESC;
        else emit(c, KIND_BYTE, ERR_NONE);
      end
      M_ESC: begin
        if (eos) abort_string(ERR_UNT_ESC);
        else begin
          pmode = M_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, "/": emit(c, KIND_BYTE, ERR_NONE);
            "b": emit(8'h08, KIND_BYTE, ERR_NONE);
            "f": emit(8'h0C, KIND_BYTE, ERR_NONE);
            "n": emit(8'h0A, KIND_BYTE, ERR_NONE);
            "r": emit(8'h0D, KIND_BYTE, ERR_NONE);
            "t": emit(8'h09, KIND_BYTE, ERR_NONE);
            "u": begin
              pmode   = M_HEX_HI;
              hex_cnt = 2'd0;
              hex_acc = 16'h0;
            end
            default: abort_string(ERR_BAD_ESC);
          endcase
        end
      end
      M_HEX_HI, M_HEX_LO: begin
        if (eos) abort_string(ERR_UNT_UNI);
        else if (!hex_nibble(c, nib)) abort_string(ERR_BAD_HEX);
        else begin
          hex_acc = {hex_acc[11:0], nib};
          if (hex_cnt != 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt = 2'd0;
            v = hex_acc;
            if (pmode == M_HEX_HI) begin
              hex_acc = 16'h0;
              if (v >= 16'hD800 && v <= 16'hDBFF) begin
                hi_bits = v[9:0];
                pmode   = M_NEED_BS;
              end else begin
                // lone low surrogates fall through here and encode as-is
                emit_code_point({5'd0, v});
                pmode = M_STR;
              end
            end else if (v < 16'hDC00 || v > 16'hDFFF) begin
              abort_string(ERR_BAD_LO);
            end else begin
              emit_code_point(21'h10000 + {1'b0, hi_bits, v[9:0]});
              hex_acc = 16'h0;
              hi_bits = 10'h0;
              pmode   = M_STR;
            end
          end
        end
      end
      M_NEED_BS: begin
        if (eos || c != CH_BSLASH) abort_string(ERR_MISS_LO);
        else pmode = M_NEED_U;
      end
      M_NEED_U: begin
        if (eos || c != "u") abort_string(ERR_MISS_LO);
        else begin
          pmode   = M_HEX_LO;
          hex_cnt = 2'd0;
          hex_acc = 16'h0;
        end
      end
      default: begin
        if (eos || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) skipped = 1'b1;
        else if (c == CH_QUOTE) begin
          reset_decoder();
          pmode = M_STR;
        end else abort_string(ERR_EXP_QUOTE);
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (step_res[i]) pending_decodes.insert(pending_decodes.size(), step_res[i]);
    end
    return skipped;
  endfunction

  // Drives one source byte and waits for its transfer.
  task automatic send_source_byte(input byte_t d, input logic eos);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= d;
    in_if.source_end <= eos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    src_items++;
  endtask

  function automatic byte_t hex_char(input logic [3:0] n);
    if (n < 4'd10) return byte_t'("0" + n);
    return byte_t'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
  endfunction

  function automatic void add_u_escape(ref src_item_t s[$], input logic [15:0] v);
    s.insert(s.size(), '{CH_BSLASH, 1'b0});
    s.insert(s.size(), '{"u", 1'b0});
    for (int i = 3; i >= 0; i--) s.insert(s.size(), '{hex_char(v[4*i +: 4]), 1'b0});
  endfunction

  function automatic void add_token(ref src_item_t s[$]);
    byte_t       esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
    byte_t       b;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: begin
        do b = byte_t'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH);
        s.insert(s.size(), '{b, 1'b0});
      end
      1: begin
        s.insert(s.size(), '{CH_BSLASH, 1'b0});
        s.insert(s.size(), '{esc_letters[$urandom_range(0, 7)], 1'b0});
      end
      2: begin
        // spread over one-, two- and three-byte encodings, skipping high surrogates
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(16'h0000, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: begin
            do v = 16'($urandom_range(16'h0800, 16'hFFFF));
            while (v >= 16'hD800 && v <= 16'hDBFF);
          end
        endcase
        add_u_escape(s, v);
      end
      3: begin
        add_u_escape(s, 16'hD800 | 16'($urandom_range(0, 10'h3FF)));
        add_u_escape(s, 16'hDC00 | 16'($urandom_range(0, 10'h3FF)));
      end
      4: add_u_escape(s, 16'hDC00 | 16'($urandom_range(0, 10'h3FF)));
      default: s.insert(s.size(), '{byte_t'($urandom_range(8'h61, 8'h7A)), 1'b0});
    endcase
  endfunction

  // One random burst: mostly well-formed strings, some broken ones, some raw noise.
  function automatic void build_burst(ref src_item_t s[$]);
    byte_t       ws_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    int unsigned pos;
    s.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4))
        s.insert(s.size(), '{byte_t'($urandom), $urandom_range(0, 7) == 0});
      return;
    end
    repeat ($urandom_range(0, 2)) s.insert(s.size(), '{ws_chars[$urandom_range(0, 5)], 1'b0});
    s.insert(s.size(), '{CH_QUOTE, 1'b0});
    repeat ($urandom_range(0, 6)) add_token(s);
    s.insert(s.size(), '{CH_QUOTE, 1'b0});
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(1, s.size() - 1);
      if ($urandom_range(0, 2) == 0) begin
        s[pos] = '{byte_t'($urandom), 1'b1};
        while (s.size() > pos + 1) void'(s.pop_back());
      end else begin
        s[pos].d = byte_t'($urandom);
      end
    end
  endfunction

  // result receiver: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        rdy;
    stall_left   = 0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 79;
        rdy       = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    dec_res_t got;
    dec_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_byte, out_if.kind, out_if.error_code, out_if.last};
      case (got.k)
        KIND_BYTE: n_bytes++;
        KIND_END:  n_ends++;
        default: begin
          n_errs++;
          codes_seen[got.c] = 1'b1;
        end
      endcase
      if (pending_decodes.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got byte=%h kind=%0d code=%0d last=%b",
                 $time, got.b, got.k, got.c, got.last);
      end else begin
        want = pending_decodes.pop_front();
        if (got.b !== want.b || got.k !== want.k || got.c !== want.c ||
            got.last !== want.last) begin
          mismatches++;
          $display("%0t: expected byte=%h kind=%0d code=%0d last=%b, got byte=%h kind=%0d code=%0d last=%b",
                   $time, want.b, want.k, want.c, want.last,
                   got.b, got.k, got.c, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_decodes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    src_item_t burst[$];
    bit        held;
    bit        paused;
    bit        skipped;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.source_end = 1'b0;
    mismatches       = 0;
    live_items       = 0;
    src_items        = 0;
    n_bytes          = 0;
    n_ends           = 0;
    n_errs           = 0;
    codes_seen       = '0;
    cycle_cnt        = 0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    held             = 1'b0;
    paused           = 1'b0;
    reset_decoder();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (STIM_TABLE[i]) begin
      send_source_byte(STIM_TABLE[i].d, STIM_TABLE[i].eos);
      skipped = decode_source_byte(STIM_TABLE[i].d, STIM_TABLE[i].eos, !STIM_TABLE[i].known);
      if (STIM_TABLE[i].known)
        pending_decodes.insert(pending_decodes.size(),
                               '{STIM_TABLE[i].b, STIM_TABLE[i].k, STIM_TABLE[i].c, 1'b1});
      if (!skipped) live_items++;
    end

    while (live_items < 420) begin
      build_burst(burst);
      foreach (burst[i]) begin
        send_source_byte(burst[i].d, burst[i].eos);
        if (!decode_source_byte(burst[i].d, burst[i].eos, 1'b1)) live_items++;
      end
      if (!held && live_items >= 120) begin
        // long output stall while input keeps coming: queue fills, input backs up
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && live_items >= 240) begin
        paused = 1'b1;
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge clk);
      end
      if (live_items >= 360) calm = 1'b1;
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d source bytes; got %0d decoded bytes, %0d closed strings, %0d errors",
             src_items, n_bytes, n_ends, n_errs);
    $display("Error codes seen (bit per code): %b, mismatches: %0d", codes_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
